// ----- src/tsga_pkg.sv -----
`timescale 1ns / 1ps
package tsga_pkg;

    localparam int FRAC_BITS           = 12;
    localparam int SIG_FRAC            = 16;
    localparam int TANH_ENTRIES_DEF    = 256;
    localparam int SIG_ENTRIES_DEF     = 64;

    localparam int DATA_W   = 16;
    localparam int MAG_W    = FRAC_BITS + 1;
    localparam int HID_W    = FRAC_BITS + 2;
    localparam int SQ_W     = 2 * FRAC_BITS + 1;
    localparam int GATE_W   = FRAC_BITS + 1;
    localparam int IN_W     = 2 * DATA_W;
    localparam int OUT_RAW  = DATA_W + HID_W + GATE_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    localparam longint Q30_ONE = longint'(1) <<< 30;

    // quotient truncated toward zero, shift and subtract
    function automatic longint div_trunc(input longint num, input longint den);
        longint a;
        longint b;
        longint q;
        longint part;
        bit     neg;
        neg  = (num < 0) != (den < 0);
        a    = (num < 0) ? -num : num;
        b    = (den < 0) ? -den : den;
        q    = 0;
        part = 0;
        for (int i = 62; i >= 0; i--) begin
            part = (part <<< 1) | ((a >>> i) & longint'(1));
            if (part >= b) begin
                part = part - b;
                q    = q | (longint'(1) <<< i);
            end
        end
        return neg ? -q : q;
    endfunction

    // exp(-f) in q30, f in [0,1]
    function automatic longint exp_series(input longint f);
        longint term;
        longint sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = -div_trunc(term * f, longint'(k) <<< 30);
            sum  = sum + term;
        end
        return (sum < 0) ? longint'(0) : sum;
    endfunction

    // exp(-t) in q30
    function automatic longint exp_neg(input longint t);
        longint whole;
        longint r;
        longint e1;
        whole = t >>> 30;
        r     = exp_series(t & (Q30_ONE - 1));
        e1    = exp_series(Q30_ONE);
        for (int n = 0; n < whole && n < 64; n++) begin
            r = (r * e1 + (Q30_ONE >>> 1)) >>> 30;
        end
        return r;
    endfunction

    function automatic longint tanh_point(input int i, input int entries);
        longint t;
        longint e;
        longint den;
        t   = div_trunc((longint'(i) * 16) <<< 30, longint'(entries));
        e   = exp_neg(t);
        den = Q30_ONE + e;
        return div_trunc(((Q30_ONE - e) <<< FRAC_BITS) + (den >>> 1), den);
    endfunction

    function automatic longint sig_point(input int j, input int entries);
        longint two_j;
        longint mag;
        longint e;
        longint den;
        longint num;
        bit     pos;
        two_j = 2 * longint'(j);
        pos   = (two_j >= longint'(entries));
        mag   = pos ? two_j - longint'(entries) : longint'(entries) - two_j;
        e     = exp_neg(div_trunc(mag <<< 30, longint'(entries)));
        den   = Q30_ONE + e;
        num   = pos ? Q30_ONE : e;
        return div_trunc((num <<< SIG_FRAC) + (den >>> 1), den);
    endfunction

endpackage

// ----- src/tsga_tanh.sv -----
`timescale 1ns / 1ps
module tsga_tanh
    import tsga_pkg::*;
#(
    parameter int ENTRIES = TANH_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic [1:0]               i_en,
    input  logic signed [DATA_W-1:0] i_preact,
    output logic signed [HID_W-1:0]  o_hidden
);

    localparam int IW     = $clog2(ENTRIES + 1);
    localparam int SPAN_B = FRAC_BITS + 3;
    localparam int POS_W  = DATA_W + IW;
    localparam int ACC_W  = SPAN_B + MAG_W + 3;

    typedef logic [MAG_W-1:0] t_tab [0:ENTRIES];

    function automatic t_tab build_tab();
        t_tab   tab;
        longint v;
        for (int i = 0; i <= ENTRIES; i++) begin
            v      = tanh_point(i, ENTRIES);
            tab[i] = v[MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab TAB = build_tab();

    logic [DATA_W:0]   n_neg_val;
    logic [DATA_W-1:0] n_mag;
    logic [POS_W-1:0]  n_pos;
    logic [IW-1:0]     n_idx;
    logic [IW-1:0]     n_idx_hi;
    logic              n_sat;

    logic              r_neg;
    logic              r_sat;
    logic [MAG_W-1:0]  r_y0;
    logic [MAG_W-1:0]  r_y1;
    logic [SPAN_B-1:0] r_rem;

    logic signed [MAG_W:0]   n_diff;
    logic signed [ACC_W-1:0] n_acc;
    logic [MAG_W-1:0]        n_y;
    logic [HID_W-1:0]        n_hid;
    logic signed [HID_W-1:0] r_hidden;

    always_comb begin
        n_neg_val = -{i_preact[DATA_W-1], i_preact};
        n_mag     = i_preact[DATA_W-1] ? n_neg_val[DATA_W-1:0] : i_preact;
        n_pos     = POS_W'(n_mag) * POS_W'(ENTRIES);
        n_idx     = n_pos[SPAN_B +: IW];
        n_sat     = (32'(n_idx) >= 32'(ENTRIES));
        n_idx_hi  = n_sat ? n_idx : n_idx + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg <= i_preact[DATA_W-1];
            r_sat <= n_sat;
            r_y0  <= TAB[n_idx];
            r_y1  <= TAB[n_idx_hi];
            r_rem <= n_pos[SPAN_B-1:0];
        end
    end

    always_comb begin
        n_diff = $signed({1'b0, r_y1}) - $signed({1'b0, r_y0});
        n_acc  = $signed(ACC_W'({r_y0, {SPAN_B{1'b0}}}))
               + ACC_W'(n_diff) * ACC_W'($signed({1'b0, r_rem}))
               + $signed(ACC_W'(1) <<< (SPAN_B - 1));
        n_y    = r_sat ? MAG_W'(1) << FRAC_BITS : n_acc[SPAN_B +: MAG_W];
        n_hid  = r_neg ? -HID_W'(n_y) : HID_W'(n_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_hidden <= $signed(n_hid);
        end
    end

    assign o_hidden = r_hidden;

endmodule

// ----- src/tsga_sigmoid.sv -----
`timescale 1ns / 1ps
module tsga_sigmoid
    import tsga_pkg::*;
#(
    parameter int ENTRIES = SIG_ENTRIES_DEF
) (
    input  logic                    i_clk,
    input  logic [1:0]              i_en,
    input  logic signed [HID_W-1:0] i_hidden,
    output logic [SIG_FRAC-1:0]     o_sig
);

    localparam int IW     = $clog2(ENTRIES + 1);
    localparam int SPAN_B = FRAC_BITS + 1;
    localparam int U_W    = FRAC_BITS + 2;
    localparam int POS_W  = U_W + IW;
    localparam int ACC_W  = SPAN_B + SIG_FRAC + 3;

    typedef logic [SIG_FRAC-1:0] t_tab [0:ENTRIES];

    function automatic t_tab build_tab();
        t_tab   tab;
        longint v;
        for (int j = 0; j <= ENTRIES; j++) begin
            v      = sig_point(j, ENTRIES);
            tab[j] = v[SIG_FRAC-1:0];
        end
        return tab;
    endfunction

    localparam t_tab TAB = build_tab();

    logic [HID_W:0]    n_u_full;
    logic [U_W-1:0]    n_u;
    logic [POS_W-1:0]  n_pos;
    logic [IW-1:0]     n_idx;
    logic [IW-1:0]     n_idx_hi;

    logic [SIG_FRAC-1:0] r_s0;
    logic [SIG_FRAC-1:0] r_s1;
    logic [SPAN_B-1:0]   r_rem;

    logic signed [SIG_FRAC:0] n_diff;
    logic signed [ACC_W-1:0]  n_acc;
    logic [SIG_FRAC-1:0]      r_sig;

    always_comb begin
        n_u_full = {i_hidden[HID_W-1], i_hidden} + ((HID_W + 1)'(1) << FRAC_BITS);
        n_u      = n_u_full[U_W-1:0];
        n_pos    = POS_W'(n_u) * POS_W'(ENTRIES);
        n_idx    = n_pos[SPAN_B +: IW];
        n_idx_hi = (32'(n_idx) >= 32'(ENTRIES)) ? n_idx : n_idx + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0  <= TAB[n_idx];
            r_s1  <= TAB[n_idx_hi];
            r_rem <= n_pos[SPAN_B-1:0];
        end
    end

    always_comb begin
        n_diff = $signed({1'b0, r_s1}) - $signed({1'b0, r_s0});
        n_acc  = $signed(ACC_W'({r_s0, {SPAN_B{1'b0}}}))
               + ACC_W'(n_diff) * ACC_W'($signed({1'b0, r_rem}))
               + $signed(ACC_W'(1) <<< (SPAN_B - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sig <= n_acc[SPAN_B +: SIG_FRAC];
        end
    end

    assign o_sig = r_sig;

endmodule

// ----- src/tanh_self_gate_activation_core.sv -----
`timescale 1ns / 1ps
// an input transaction passes through register stages 1 to 6 before its result reaches the master side
// throughput: one transaction per cycle while the master side accepts, six register stages each holding one item
// a stalled master side holds the pipe; bubbles close up as items move forward
// reset (synchronous, active low) clears all stage valid bits; data registers keep
// whatever they hold and the lookup tables are constant logic
module tanh_self_gate_activation_core
    import tsga_pkg::*;
#(
    parameter int TANH_ENTRIES    = TANH_ENTRIES_DEF,
    parameter int SIGMOID_ENTRIES = SIG_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // x_in, rec_in
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // preact_out, hidden_out, gated_out, zero pad
    output logic             o_m_tlast
);

    localparam int NSTG   = 6;
    localparam int PROD_W = SQ_W + SIG_FRAC + 1;
    localparam int GSH    = FRAC_BITS + SIG_FRAC;

    logic [NSTG:1] r_v;
    logic [NSTG:1] n_en;

    logic [DATA_W-1:0] r_pre [1:NSTG];
    logic              r_last [1:NSTG];

    logic signed [DATA_W:0]   n_sum;
    logic [DATA_W-1:0]        n_preact;

    logic signed [HID_W-1:0]  w_hid3;
    logic signed [HID_W-1:0]  r_h4;
    logic signed [HID_W-1:0]  r_h5;
    logic signed [HID_W-1:0]  r_h6;
    logic [2*HID_W-1:0]       n_sq_full;
    logic [SQ_W-1:0]          r_sq4;
    logic [SQ_W-1:0]          r_sq5;
    logic [SIG_FRAC-1:0]      w_sig5;
    logic [PROD_W-1:0]        n_prod;
    logic [GATE_W-1:0]        r_g6;

    always_comb begin
        n_en[NSTG] = !r_v[NSTG] || i_m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_s_tready = n_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[1]) begin
                r_v[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // saturating add
    always_comb begin
        n_sum = $signed({i_s_tdata[DATA_W-1], i_s_tdata[DATA_W-1:0]})
              + $signed({i_s_tdata[IN_W-1], i_s_tdata[IN_W-1:DATA_W]});
        if (n_sum[DATA_W] != n_sum[DATA_W-1]) begin
            n_preact = n_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_preact = n_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_pre[1]  <= n_preact;
            r_last[1] <= i_s_tlast;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (n_en[k]) begin
                r_pre[k]  <= r_pre[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    tsga_tanh #(
        .ENTRIES (TANH_ENTRIES)
    ) u_tanh (
        .i_clk    (i_clk),
        .i_en     (n_en[3:2]),
        .i_preact ($signed(r_pre[1])),
        .o_hidden (w_hid3)
    );

    tsga_sigmoid #(
        .ENTRIES (SIGMOID_ENTRIES)
    ) u_sigmoid (
        .i_clk    (i_clk),
        .i_en     (n_en[5:4]),
        .i_hidden (w_hid3),
        .o_sig    (w_sig5)
    );

    assign n_sq_full = w_hid3 * w_hid3;
    assign n_prod    = PROD_W'(r_sq5) * PROD_W'(w_sig5) + (PROD_W'(1) << (GSH - 1));

    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r_h4  <= w_hid3;
            r_sq4 <= n_sq_full[SQ_W-1:0];
        end
        if (n_en[5]) begin
            r_h5  <= r_h4;
            r_sq5 <= r_sq4;
        end
        if (n_en[6]) begin
            r_h6 <= r_h5;
            r_g6 <= n_prod[GSH +: GATE_W];
        end
    end

    assign o_m_tvalid = r_v[NSTG];
    assign o_m_tlast  = r_last[NSTG];
    assign o_m_tdata  = OUT_W'({r_g6, r_h6, r_pre[NSTG]});

`ifndef SYNTHESIS
    a_gate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(r_g6) <= (32'(1) << FRAC_BITS)))
        else $error("gated result above one");

    a_hid_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_pre[NSTG][DATA_W-1]) |-> !r_h6[HID_W-1])
        else $error("hidden sign differs from pre-activation sign");

    a_zero_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_h6 == '0) |-> (r_g6 == '0))
        else $error("nonzero gate for zero hidden");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NSTG] |-> o_s_tready)
        else $error("input stalled with empty output stage");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[1])
        else $error("accepted transaction lost at first stage");
`endif

endmodule

// ----- dv/tanh_self_gate_activation_core_tb.sv -----
`timescale 1ns / 1ps
module tanh_self_gate_activation_core_tb;
    import tsga_pkg::*;

    localparam int TANH_N     = 256;
    localparam int SIG_N      = 64;
    localparam int N_PHASE    = 4;
    localparam int PHASE_ITEMS = 412;
    localparam int LIMIT      = 200000;
    localparam int DRAIN      = 12;
    localparam longint ONE_Q30 = longint'(1) << 30;

    typedef struct packed {
        logic [DATA_W-1:0] preact;
        logic [HID_W-1:0]  hidden;
        logic [GATE_W-1:0] gated;
        logic              last;
    } act_t;

    class activation_scoreboard;
        longint tanh_pts[0:TANH_N];
        longint sig_pts[0:SIG_N];
        act_t   pending_acts[$];
        int     errors;

        // exp(-f) in q30 for f in [0,1], 21-term series
        function longint exp_frac(input longint f);
            longint term;
            longint total;
            term  = ONE_Q30;
            total = ONE_Q30;
            for (int k = 1; k <= 20; k++) begin
                term  = -((term * f) / (longint'(k) << 30));
                total = total + term;
            end
            return (total < 0) ? longint'(0) : total;
        endfunction

        function longint exp_neg_q30(input longint t);
            longint whole;
            longint r;
            longint e1;
            whole = t >> 30;
            r     = exp_frac(t & (ONE_Q30 - 1));
            e1    = exp_frac(ONE_Q30);
            for (longint n = 0; n < whole && n < 64; n++) begin
                r = (r * e1 + (ONE_Q30 >> 1)) >> 30;
            end
            return r;
        endfunction

        function new();
            longint e;
            longint den;
            longint two_j;
            longint mag;
            longint num;
            bit     up;
            errors = 0;
            for (int i = 0; i <= TANH_N; i++) begin
                e   = exp_neg_q30(((longint'(i) * 16) << 30) / TANH_N);
                den = ONE_Q30 + e;
                tanh_pts[i] = (((ONE_Q30 - e) << FRAC_BITS) + den / 2) / den;
            end
            for (int j = 0; j <= SIG_N; j++) begin
                two_j = 2 * longint'(j);
                up    = (two_j >= SIG_N);
                mag   = up ? two_j - SIG_N : SIG_N - two_j;
                e     = exp_neg_q30((mag << 30) / SIG_N);
                den   = ONE_Q30 + e;
                num   = up ? ONE_Q30 : e;
                sig_pts[j] = ((num << SIG_FRAC) + den / 2) / den;
            end
        endfunction

        // odd-symmetric: magnitude rounded first, sign applied after
        function longint tanh_q(input int p);
            bit     neg;
            longint a;
            longint span;
            longint pos;
            longint idx;
            longint rem;
            longint y;
            neg  = (p < 0);
            a    = neg ? -longint'(p) : longint'(p);
            span = longint'(8) << FRAC_BITS;
            pos  = a * TANH_N;
            idx  = pos / span;
            rem  = pos % span;
            if (idx >= TANH_N) begin
                y = longint'(1) << FRAC_BITS;
            end else begin
                y = (tanh_pts[idx] * (span - rem) + tanh_pts[idx + 1] * rem + span / 2) / span;
            end
            return neg ? -y : y;
        endfunction

        function longint sigmoid_q(input longint h);
            longint one;
            longint u;
            longint span;
            longint pos;
            longint idx;
            longint rem;
            one  = longint'(1) << FRAC_BITS;
            u    = h + one;
            span = longint'(2) << FRAC_BITS;
            if (u < 0) u = 0;
            if (u > 2 * one) u = 2 * one;
            pos = u * SIG_N;
            idx = pos / span;
            rem = pos % span;
            if (idx >= SIG_N) return sig_pts[SIG_N];
            return (sig_pts[idx] * (span - rem) + sig_pts[idx + 1] * rem + span / 2) / span;
        endfunction

        function void note_sample(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] rec,
                                  input logic last);
            int     sum;
            longint h;
            longint sq;
            longint s;
            longint g;
            act_t   r;
            sum = int'($signed(x)) + int'($signed(rec));
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            h  = tanh_q(sum);
            sq = h * h;
            s  = sigmoid_q(h);
            g  = (sq * s + (longint'(1) << (FRAC_BITS + SIG_FRAC - 1))) >> (FRAC_BITS + SIG_FRAC);
            r.preact = sum[DATA_W-1:0];
            r.hidden = h[HID_W-1:0];
            r.gated  = g[GATE_W-1:0];
            r.last   = last;
            pending_acts.push_back(r);
        endfunction

        function void check_act(input logic [OUT_W-1:0] data, input logic last);
            act_t exp_act;
            logic [DATA_W-1:0] preact;
            logic [HID_W-1:0]  hidden;
            logic [GATE_W-1:0] gated;
            preact = data[DATA_W-1:0];
            hidden = data[DATA_W +: HID_W];
            gated  = data[DATA_W + HID_W +: GATE_W];
            if (pending_acts.size() == 0) begin
                $display("%0t unexpected transaction: preact %0d hidden %0d gated %0d last %0b",
                         $time, $signed(preact), $signed(hidden), gated, last);
                errors++;
                return;
            end
            exp_act = pending_acts.pop_front();
            if (preact !== exp_act.preact) begin
                $display("%0t preact: expected %0d, got %0d", $time,
                         $signed(exp_act.preact), $signed(preact));
                errors++;
            end
            if (hidden !== exp_act.hidden) begin
                $display("%0t hidden: expected %0d, got %0d", $time,
                         $signed(exp_act.hidden), $signed(hidden));
                errors++;
            end
            if (gated !== exp_act.gated) begin
                $display("%0t gated: expected %0d, got %0d", $time, exp_act.gated, gated);
                errors++;
            end
            if (last !== exp_act.last) begin
                $display("%0t last: expected %0b, got %0b", $time, exp_act.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_acts.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycles = 0;
    activation_scoreboard sb = new();

    tanh_self_gate_activation_core #(
        .TANH_ENTRIES(TANH_N),
        .SIGMOID_ENTRIES(SIG_N)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            sb.note_sample(s_tdata[DATA_W-1:0], s_tdata[IN_W-1:DATA_W], s_tlast);
        end
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_act(m_tdata, m_tlast);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tanh_self_gate_activation_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input int x, input int rec, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rec[DATA_W-1:0], x[DATA_W-1:0]};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_random();
        int x;
        int rec;
        int mode;
        bit neg;
        mode = $urandom_range(3);
        neg  = $urandom_range(1);
        case (mode)
            0: begin
                x   = $urandom_range(65535);
                rec = $urandom_range(65535);
            end
            // unsaturated tanh region
            1: begin
                x   = $urandom_range(24576) - 12288;
                rec = $urandom_range(8192) - 4096;
            end
            // sum overflow toward the rails
            2: begin
                x   = neg ? -32768 + $urandom_range(8191) : 32767 - $urandom_range(8191);
                rec = neg ? -32768 + $urandom_range(24575) : 32767 - $urandom_range(24575);
            end
            // around tanh table points
            default: begin
                x   = $urandom_range(255) * 128 + $urandom_range(2) - 1;
                x   = neg ? -x : x;
                rec = 0;
            end
        endcase
        send_sample(x, rec, $urandom_range(7) == 0);
    endtask

    int src_pcts[N_PHASE]  = '{0, 66, 0, 27};
    int sink_pcts[N_PHASE] = '{0, 0, 66, 27};

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(0, 0, 1'b0);
        send_sample(1, 0, 1'b1);
        send_sample(-1, 0, 1'b0);
        send_sample(32767, 32767, 1'b0);
        send_sample(-32768, -32768, 1'b1);
        send_sample(32767, -32768, 1'b0);
        send_sample(32767, 0, 1'b0);
        send_sample(-32768, 0, 1'b0);
        send_sample(0, -32768, 1'b1);
        send_sample(16384, 16384, 1'b0);
        send_sample(-16384, -16385, 1'b0);
        send_sample(128, 0, 1'b0);
        send_sample(64, 0, 1'b0);
        send_sample(-64, 0, 1'b1);
        send_sample(4096, 0, 1'b0);
        send_sample(-4096, 0, 1'b0);
        send_sample(2048, 2048, 1'b0);
        send_sample(32640, 0, 1'b0);
        send_sample(-32767, 0, 1'b1);
        send_sample(21845, -10923, 1'b0);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            src_idle_pct   = src_pcts[ph];
            sink_stall_pct = sink_pcts[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.errors == 0) begin
            $display("tanh_self_gate_activation_core_tb: done, clean");
        end else begin
            $display("tanh_self_gate_activation_core_tb: done, errors");
        end
        $finish;
    end

endmodule
